// ----- src/sett_pkg.sv -----
package sett_pkg;

    localparam int MAX_TIMERS_DFLT = 32;
    localparam int TIME_W     = 48;
    localparam int DLY_W      = 32;
    localparam int TAG_W      = 32;
    localparam int ID_W       = 8;
    localparam int KIND_W     = 3;
    localparam int OP_W       = 2;
    localparam int RESULT_CAP = 32;
    localparam int FIRE_W     = 6;   // count of fired timers, 0..RESULT_CAP
    localparam int FIRE_AW    = 5;   // address into the fired list
    localparam int CMPW       = 9;   // common width for mixed counter compares

    localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OP_W-1:0] OP_EVAL   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_CREATED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CANCEL  = 3'd4;

    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [DLY_W-1:0]  period;
        logic              periodic;
        logic [TAG_W-1:0]  tag;
    } timer_rec_t;

    localparam int REC_W = $bits(timer_rec_t);

    typedef enum logic [4:0] {
        S_IDLE,
        S_C_SEARCH,
        S_INS_RD_ORD,
        S_INS_RD_REC,
        S_INS_CMP,
        S_SH_RD,
        S_SH_WR,
        S_INS_PUT,
        S_X_FIND_RD,
        S_X_FIND_CMP,
        S_X_SH_RD,
        S_X_SH_WR,
        S_E_RD_ORD,
        S_E_RD_REC,
        S_E_CMP,
        S_E_END,
        S_E_CP_RD,
        S_E_CP_WR,
        S_E_RI_RD,
        S_E_RI_REC,
        S_E_RI_UPD,
        S_EMIT
    } state_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                   input logic [DLY_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W + 1 - DLY_W){1'b0}}, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

// ----- src/sorted_event_timer_table_core.sv -----
// Channel | Direction | Handshake            | Payload
// input   | in        | in_valid / in_ready  | opcode, now_ms, delay_ms, periodic,
//         |           |                      | event_tag, cancel_id
// output  | out       | out_valid / out_ready| kind, timer_id, fired_tag, last
//
// Flow: one item at a time; in_ready is high only in the idle state.
// Create: an id search over up to MAX_TIMERS ids, then a walk over the list
// entries passed over and a shift of the entries behind. Cancel: a search of
// the list and a shift of the entries behind. Evaluate: a read and due test
// per fired timer, compaction of the remaining entries, then one insertion walk
// per periodic timer. The one order memory and the one shared 48-bit comparator serialise these steps.
// Reset: asynchronous, clears the id map, counters and sequencer; no sweep.
// Stalls: an output transfer that waits holds the sequencer at its next result.
module sorted_event_timer_table_core #(
    parameter int MAX_TIMERS = sett_pkg::MAX_TIMERS_DFLT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sett_pkg::OP_W-1:0]    opcode,
    input  logic [sett_pkg::TIME_W-1:0]  now_ms,
    input  logic [sett_pkg::DLY_W-1:0]   delay_ms,
    input  logic                         periodic,
    input  logic [sett_pkg::TAG_W-1:0]   event_tag,
    input  logic [sett_pkg::ID_W-1:0]    cancel_id,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sett_pkg::KIND_W-1:0]  kind,
    output logic [sett_pkg::ID_W-1:0]    timer_id,
    output logic [sett_pkg::TAG_W-1:0]   fired_tag,
    output logic                         last
);

    import sett_pkg::*;

    // CW: width of counts 0..MAX_TIMERS and of id indexes into the id map
    localparam int CW  = $clog2(MAX_TIMERS + 1);
    // OAW: address width of the expiry order list
    localparam int OAW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic [OP_W-1:0]    op_reg, op_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [DLY_W-1:0]   delay_reg, delay_next;
    logic               per_reg, per_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [ID_W-1:0]    cid_reg, cid_next;

    logic [MAX_TIMERS:0] in_use_reg, in_use_next;
    logic [ID_W-1:0]    last_id_reg, last_id_next;
    logic [CW-1:0]      active_reg, active_next;
    logic [ID_W-1:0]    cand_reg, cand_next;
    logic [CW-1:0]      iter_reg, iter_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [CW-1:0]      q_reg, q_next;
    logic [FIRE_W-1:0]  f_reg, f_next;
    logic [FIRE_W-1:0]  ri_reg, ri_next;
    logic [ID_W-1:0]    new_id_reg, new_id_next;
    logic [TIME_W-1:0]  new_exp_reg, new_exp_next;
    logic [ID_W-1:0]    cur_id_reg, cur_id_next;

    // result waiting to go to the output register
    logic [KIND_W-1:0]  pend_kind_reg, pend_kind_next;
    logic [ID_W-1:0]    pend_id_reg, pend_id_next;
    logic [TAG_W-1:0]   pend_tag_reg, pend_tag_next;
    logic               pend_last_reg, pend_last_next;

    logic               out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  kind_reg;
    logic [ID_W-1:0]    timer_id_reg;
    logic [TAG_W-1:0]   fired_tag_reg;
    logic               last_reg;

    // memory ports
    logic               ord_we;
    logic [OAW-1:0]     ord_waddr, ord_raddr;
    logic [ID_W-1:0]    ord_wdata, ord_rdata;
    logic               rec_we;
    logic [CW-1:0]      rec_waddr, rec_raddr;
    logic [REC_W-1:0]   rec_wdata, rec_rdata;
    logic               fir_we;
    logic [FIRE_AW-1:0] fir_waddr, fir_raddr;
    logic [ID_W-1:0]    fir_wdata, fir_rdata;

    timer_rec_t         rec_q, rec_w;

    // shared datapath
    logic [TIME_W-1:0]  add_a, sat_sum, cmp_b;
    logic [DLY_W-1:0]   add_b;
    logic               rec_le;
    logic [ID_W-1:0]    cand_step;
    logic               slot_free, load_out;
    logic               table_full, cancel_hit, iter_last;
    logic               scan_more, cp_more, x_more;
    logic [CMPW-1:0]    cp_src, x_src;

    // shift source for an insertion: entry q-1 moves to q
    function automatic logic [OAW-1:0] q_next_src(input logic [CW-1:0] q);
        logic [CW-1:0] d;
        d = q - CW'(1);
        return d[OAW-1:0];
    endfunction

    assign rec_q = timer_rec_t'(rec_rdata);

    // one saturating adder: creation expiry or periodic advance
    assign add_a   = (state_reg == S_C_SEARCH) ? now_reg : rec_q.expiry;
    assign add_b   = (state_reg == S_C_SEARCH) ? delay_reg : rec_q.period;
    assign sat_sum = sat_add(add_a, add_b);

    // one comparator: list walk for insertion, due test during evaluate
    assign cmp_b  = (state_reg == S_E_CMP) ? now_reg : new_exp_reg;
    assign rec_le = (rec_q.expiry <= cmp_b);

    assign cand_step  = (cand_reg >= ID_W'(MAX_TIMERS)) ? ID_W'(1) : cand_reg + ID_W'(1);
    assign table_full = (active_reg >= CW'(MAX_TIMERS));
    assign cancel_hit = (cancel_id != '0) && (cancel_id <= ID_W'(MAX_TIMERS))
                        && in_use_reg[cancel_id[CW-1:0]];
    assign iter_last  = (iter_reg == CW'(MAX_TIMERS - 1));
    assign scan_more  = (CMPW'(f_reg) < CMPW'(active_reg))
                        && (CMPW'(f_reg) < CMPW'(RESULT_CAP));
    assign cp_src     = CMPW'(q_reg) + CMPW'(f_reg);
    assign cp_more    = (cp_src < CMPW'(active_reg));
    assign x_src      = CMPW'(q_reg) + CMPW'(1);
    assign x_more     = (x_src < CMPW'(active_reg));

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);

    // expiry order list of MAX_TIMERS entries; the fired list is full at RESULT_CAP entries
    sett_ram #(.WIDTH(ID_W), .DEPTH(MAX_TIMERS)) u_order (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    sett_ram #(.WIDTH(REC_W), .DEPTH(MAX_TIMERS + 1)) u_rec (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    sett_ram #(.WIDTH(ID_W), .DEPTH(RESULT_CAP)) u_fired (
        .clk   (clk),
        .we    (fir_we),
        .waddr (fir_waddr),
        .wdata (fir_wdata),
        .raddr (fir_raddr),
        .rdata (fir_rdata)
    );

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (opcode)
                        OP_CREATE: state_next = table_full ? S_EMIT : S_C_SEARCH;
                        OP_CANCEL: state_next = cancel_hit ? S_X_FIND_RD : S_EMIT;
                        OP_EVAL:   state_next = S_E_RD_ORD;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_C_SEARCH:
            begin
                if (!in_use_reg[cand_step[CW-1:0]])
                begin
                    state_next = S_INS_RD_ORD;
                end
                else if (iter_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_INS_RD_ORD: state_next = (pos_reg < active_reg) ? S_INS_RD_REC : S_SH_RD;
            S_INS_RD_REC: state_next = S_INS_CMP;
            S_INS_CMP:    state_next = rec_le ? S_INS_RD_ORD : S_SH_RD;
            S_SH_RD:      state_next = (q_reg > pos_reg) ? S_SH_WR : S_INS_PUT;
            S_SH_WR:      state_next = S_SH_RD;
            S_INS_PUT:    state_next = (op_reg == OP_EVAL) ? S_E_RI_RD : S_EMIT;
            S_X_FIND_RD:  state_next = (pos_reg < active_reg) ? S_X_FIND_CMP : S_EMIT;
            S_X_FIND_CMP: state_next = (ord_rdata == cid_reg) ? S_X_SH_RD : S_X_FIND_RD;
            S_X_SH_RD:    state_next = x_more ? S_X_SH_WR : S_EMIT;
            S_X_SH_WR:    state_next = S_X_SH_RD;
            S_E_RD_ORD:   state_next = scan_more ? S_E_RD_REC : S_E_END;
            S_E_RD_REC:   state_next = S_E_CMP;
            S_E_CMP:
            begin
                if (!rec_le)
                begin
                    state_next = S_E_END;
                end
                else if ((f_reg == '0) || slot_free)
                begin
                    state_next = S_E_RD_ORD;
                end
            end
            S_E_END:      state_next = S_EMIT;
            S_E_CP_RD:    state_next = cp_more ? S_E_CP_WR : S_E_RI_RD;
            S_E_CP_WR:    state_next = S_E_CP_RD;
            S_E_RI_RD:    state_next = (ri_reg < f_reg) ? S_E_RI_REC : S_IDLE;
            S_E_RI_REC:   state_next = S_E_RI_UPD;
            S_E_RI_UPD:   state_next = rec_q.periodic ? S_INS_RD_ORD : S_E_RI_RD;
            S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ret_reg;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // sequencer: datapath controls and register updates
    always_comb
    begin
        ret_next       = ret_reg;
        op_next        = op_reg;
        now_next       = now_reg;
        delay_next     = delay_reg;
        per_next       = per_reg;
        tag_next       = tag_reg;
        cid_next       = cid_reg;
        in_use_next    = in_use_reg;
        last_id_next   = last_id_reg;
        active_next    = active_reg;
        cand_next      = cand_reg;
        iter_next      = iter_reg;
        pos_next       = pos_reg;
        q_next         = q_reg;
        f_next         = f_reg;
        ri_next        = ri_reg;
        new_id_next    = new_id_reg;
        new_exp_next   = new_exp_reg;
        cur_id_next    = cur_id_reg;
        pend_kind_next = pend_kind_reg;
        pend_id_next   = pend_id_reg;
        pend_tag_next  = pend_tag_reg;
        pend_last_next = pend_last_reg;
        load_out       = 1'b0;
        ord_we         = 1'b0;
        ord_waddr      = '0;
        ord_wdata      = '0;
        ord_raddr      = '0;
        rec_we         = 1'b0;
        rec_waddr      = '0;
        rec_raddr      = '0;
        rec_w          = '0;
        fir_we         = 1'b0;
        fir_waddr      = '0;
        fir_wdata      = '0;
        fir_raddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next        = opcode;
                    now_next       = now_ms;
                    delay_next     = delay_ms;
                    per_next       = periodic;
                    tag_next       = event_tag;
                    cid_next       = cancel_id;
                    cand_next      = last_id_reg;
                    iter_next      = '0;
                    pos_next       = '0;
                    f_next         = '0;
                    ret_next       = S_IDLE;
                    pend_tag_next  = '0;
                    pend_last_next = 1'b1;
                    pend_id_next   = '0;
                    pend_kind_next = (opcode == OP_CANCEL) ? KIND_CANCEL : KIND_REFUSED;
                    if ((opcode == OP_CANCEL) && cancel_hit)
                    begin
                        pend_id_next = cancel_id;
                    end
                end
            end
            S_C_SEARCH:
            begin
                // walk the id map round-robin, wrapping to id 1
                if (!in_use_reg[cand_step[CW-1:0]])
                begin
                    in_use_next[cand_step[CW-1:0]] = 1'b1;
                    last_id_next   = cand_step;
                    new_id_next    = cand_step;
                    new_exp_next   = sat_sum;
                    rec_we         = 1'b1;
                    rec_waddr      = cand_step[CW-1:0];
                    rec_w.expiry   = sat_sum;
                    rec_w.period   = delay_reg;
                    rec_w.periodic = per_reg;
                    rec_w.tag      = tag_reg;
                    pos_next       = '0;
                    pend_kind_next = KIND_CREATED;
                    pend_id_next   = cand_step;
                end
                else
                begin
                    cand_next = cand_step;
                    iter_next = iter_reg + CW'(1);
                end
            end
            S_INS_RD_ORD:
            begin
                ord_raddr = pos_reg[OAW-1:0];
                if (pos_reg >= active_reg)
                begin
                    q_next = active_reg;
                end
            end
            S_INS_RD_REC:
            begin
                rec_raddr = ord_rdata[CW-1:0];
            end
            S_INS_CMP:
            begin
                // equal expiry goes behind: insertion order holds on ties
                if (rec_le)
                begin
                    pos_next = pos_reg + CW'(1);
                end
                else
                begin
                    q_next = active_reg;
                end
            end
            S_SH_RD:
            begin
                ord_raddr = q_next_src(q_reg);
            end
            S_SH_WR:
            begin
                ord_we    = 1'b1;
                ord_waddr = q_reg[OAW-1:0];
                ord_wdata = ord_rdata;
                q_next    = q_reg - CW'(1);
            end
            S_INS_PUT:
            begin
                ord_we      = 1'b1;
                ord_waddr   = pos_reg[OAW-1:0];
                ord_wdata   = new_id_reg;
                active_next = active_reg + CW'(1);
                ri_next     = ri_reg + FIRE_W'(1);
            end
            S_X_FIND_RD:
            begin
                ord_raddr = pos_reg[OAW-1:0];
            end
            S_X_FIND_CMP:
            begin
                if (ord_rdata == cid_reg)
                begin
                    q_next = pos_reg;
                end
                else
                begin
                    pos_next = pos_reg + CW'(1);
                end
            end
            S_X_SH_RD:
            begin
                ord_raddr = x_src[OAW-1:0];
                if (!x_more)
                begin
                    active_next = active_reg - CW'(1);
                    in_use_next[cid_reg[CW-1:0]] = 1'b0;
                end
            end
            S_X_SH_WR:
            begin
                ord_we    = 1'b1;
                ord_waddr = q_reg[OAW-1:0];
                ord_wdata = ord_rdata;
                q_next    = q_reg + CW'(1);
            end
            S_E_RD_ORD:
            begin
                ord_raddr = OAW'(f_reg);
            end
            S_E_RD_REC:
            begin
                rec_raddr   = ord_rdata[CW-1:0];
                cur_id_next = ord_rdata;
            end
            S_E_CMP:
            begin
                // hold one fired result back until the next due test sets last
                rec_raddr = cur_id_reg[CW-1:0];
                if (rec_le && ((f_reg == '0) || slot_free))
                begin
                    load_out       = (f_reg != '0);
                    fir_we         = 1'b1;
                    fir_waddr      = f_reg[FIRE_AW-1:0];
                    fir_wdata      = cur_id_reg;
                    pend_kind_next = KIND_FIRED;
                    pend_id_next   = cur_id_reg;
                    pend_tag_next  = rec_q.tag;
                    pend_last_next = 1'b0;
                    f_next         = f_reg + FIRE_W'(1);
                end
            end
            S_E_END:
            begin
                pend_last_next = 1'b1;
                q_next         = '0;
                ri_next        = '0;
                if (f_reg == '0)
                begin
                    pend_kind_next = KIND_NONE;
                    pend_id_next   = '0;
                    pend_tag_next  = '0;
                    ret_next       = S_IDLE;
                end
                else
                begin
                    ret_next = S_E_CP_RD;
                end
            end
            S_E_CP_RD:
            begin
                // drop the fired entries from the head of the list
                ord_raddr = cp_src[OAW-1:0];
                if (!cp_more)
                begin
                    active_next = active_reg - CW'(f_reg);
                end
            end
            S_E_CP_WR:
            begin
                ord_we    = 1'b1;
                ord_waddr = q_reg[OAW-1:0];
                ord_wdata = ord_rdata;
                q_next    = q_reg + CW'(1);
            end
            S_E_RI_RD:
            begin
                fir_raddr = ri_reg[FIRE_AW-1:0];
            end
            S_E_RI_REC:
            begin
                rec_raddr   = fir_rdata[CW-1:0];
                new_id_next = fir_rdata;
            end
            S_E_RI_UPD:
            begin
                // advance periodics by their period, free one-shots
                if (rec_q.periodic)
                begin
                    rec_we         = 1'b1;
                    rec_waddr      = new_id_reg[CW-1:0];
                    rec_w          = rec_q;
                    rec_w.expiry   = sat_sum;
                    new_exp_next   = sat_sum;
                    pos_next       = '0;
                end
                else
                begin
                    in_use_next[new_id_reg[CW-1:0]] = 1'b0;
                    ri_next = ri_reg + FIRE_W'(1);
                end
            end
            S_EMIT:
            begin
                load_out = slot_free;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    assign rec_wdata = rec_w;

    assign out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            in_use_reg    <= '0;
            last_id_reg   <= '0;
            active_reg    <= '0;
            f_reg         <= '0;
            ri_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            in_use_reg    <= in_use_next;
            last_id_reg   <= last_id_next;
            active_reg    <= active_next;
            f_reg         <= f_next;
            ri_reg        <= ri_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        now_reg       <= now_next;
        delay_reg     <= delay_next;
        per_reg       <= per_next;
        tag_reg       <= tag_next;
        cid_reg       <= cid_next;
        cand_reg      <= cand_next;
        iter_reg      <= iter_next;
        pos_reg       <= pos_next;
        q_reg         <= q_next;
        new_id_reg    <= new_id_next;
        new_exp_reg   <= new_exp_next;
        cur_id_reg    <= cur_id_next;
        pend_kind_reg <= pend_kind_next;
        pend_id_reg   <= pend_id_next;
        pend_tag_reg  <= pend_tag_next;
        pend_last_reg <= pend_last_next;
        if (load_out)
        begin
            kind_reg      <= pend_kind_reg;
            timer_id_reg  <= pend_id_reg;
            fired_tag_reg <= pend_tag_reg;
            last_reg      <= pend_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign timer_id  = timer_id_reg;
    assign fired_tag = fired_tag_reg;
    assign last      = last_reg;

    // the list never holds more entries than there are ids
    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg <= CW'(MAX_TIMERS))
        else $error("active count above table size");

    // between items, ids in use match the list length
    a_ids_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(in_use_reg) == int'(active_reg)))
        else $error("id map and list length disagree");

    // id zero is never handed out
    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !in_use_reg[0])
        else $error("id zero marked in use");

    // a result is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && out_valid_reg) |-> out_ready)
        else $error("pending result overwritten");

    // one evaluate fires at most the result cap
    a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
        f_reg <= FIRE_W'(RESULT_CAP))
        else $error("fired count above cap");

endmodule

// ----- src/sett_ram.sv -----
module sett_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- dv/sett_result_checker.sv -----
`timescale 1ns / 100ps

module sett_result_checker #(
    parameter int MAX_TIMERS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [sett_pkg::OP_W-1:0]    opcode,
    input  logic [sett_pkg::TIME_W-1:0]  now_ms,
    input  logic [sett_pkg::DLY_W-1:0]   delay_ms,
    input  logic                         periodic,
    input  logic [sett_pkg::TAG_W-1:0]   event_tag,
    input  logic [sett_pkg::ID_W-1:0]    cancel_id,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [sett_pkg::KIND_W-1:0]  kind,
    input  logic [sett_pkg::ID_W-1:0]    timer_id,
    input  logic [sett_pkg::TAG_W-1:0]   fired_tag,
    input  logic                         last,
    output int                           fail_count,
    output int                           pending,
    output int                           fire_count
);
    import sett_pkg::*;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [TAG_W-1:0]  tag;
        logic              last;
    } timer_event_t;

    timer_event_t         due_events[$];
    logic                 slot_busy[MAX_TIMERS+1];
    logic [TIME_W-1:0]    slot_expiry[MAX_TIMERS+1];
    logic [DLY_W-1:0]     slot_period[MAX_TIMERS+1];
    logic                 slot_repeat[MAX_TIMERS+1];
    logic [TAG_W-1:0]     slot_tag[MAX_TIMERS+1];
    int                   order_list[MAX_TIMERS];
    int                   live_count;
    int                   recent_id;

    function automatic logic [TIME_W-1:0] clamp_add(logic [TIME_W-1:0] t,
                                                    logic [DLY_W-1:0] d);
        logic [TIME_W:0] s;
        s = {1'b0, t} + {17'b0, d};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    task automatic place_in_order(int id);
        int p;
        p = 0;
        if (live_count >= MAX_TIMERS)
            return;
        while (p < live_count && slot_expiry[order_list[p]] <= slot_expiry[id])
            p++;
        for (int q = live_count; q > p; q--)
            order_list[q] = order_list[q-1];
        order_list[p] = id;
        live_count++;
    endtask

    task automatic post(logic [KIND_W-1:0] k, int id, logic [TAG_W-1:0] t);
        timer_event_t e;
        e.kind = k;
        e.id   = id[ID_W-1:0];
        e.tag  = t;
        e.last = 1'b0;
        due_events.push_back(e);
    endtask

    task automatic predict_timers();
        int cand;
        int got;
        int fired[RESULT_CAP];
        int f;
        got = 0;
        f = 0;
        case (opcode)
            OP_CREATE: begin
                if (live_count < MAX_TIMERS) begin
                    cand = recent_id;
                    for (int i = 0; i < MAX_TIMERS && got == 0; i++) begin
                        cand = (cand >= MAX_TIMERS) ? 1 : cand + 1;
                        if (!slot_busy[cand])
                            got = cand;
                    end
                end
                if (got == 0) begin
                    post(KIND_REFUSED, 0, '0);
                end else begin
                    slot_busy[got]   = 1'b1;
                    recent_id        = got;
                    slot_expiry[got] = clamp_add(now_ms, delay_ms);
                    slot_period[got] = delay_ms;
                    slot_repeat[got] = periodic;
                    slot_tag[got]    = event_tag;
                    place_in_order(got);
                    post(KIND_CREATED, got, '0);
                end
                due_events[$].last = 1'b1;
            end
            OP_CANCEL: begin
                if (cancel_id != 0 && cancel_id <= MAX_TIMERS && slot_busy[cancel_id]) begin
                    got = cancel_id;
                    for (int p = 0; p < live_count; p++) begin
                        if (order_list[p] == got) begin
                            for (int q = p; q + 1 < live_count; q++)
                                order_list[q] = order_list[q+1];
                            live_count--;
                            break;
                        end
                    end
                    slot_busy[got] = 1'b0;
                end
                post(KIND_CANCEL, got, '0);
                due_events[$].last = 1'b1;
            end
            OP_EVAL: begin
                while (f < live_count && f < RESULT_CAP &&
                       now_ms >= slot_expiry[order_list[f]]) begin
                    fired[f] = order_list[f];
                    post(KIND_FIRED, fired[f], slot_tag[fired[f]]);
                    f++;
                end
                if (f == 0) begin
                    post(KIND_NONE, 0, '0);
                end else begin
                    fire_count += f;
                    for (int i = 0; i + f < live_count; i++)
                        order_list[i] = order_list[i+f];
                    live_count -= f;
                    for (int i = 0; i < f; i++) begin
                        if (slot_repeat[fired[i]]) begin
                            slot_expiry[fired[i]] = clamp_add(slot_expiry[fired[i]],
                                                              slot_period[fired[i]]);
                            place_in_order(fired[i]);
                        end else begin
                            slot_busy[fired[i]] = 1'b0;
                        end
                    end
                end
                due_events[$].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic report(string what, int got_v, int want_v);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got_v, want_v);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        fire_count = 0;
        live_count = 0;
        recent_id  = 0;
        for (int i = 0; i <= MAX_TIMERS; i++)
            slot_busy[i] = 1'b0;
    end

    assign pending = due_events.size();

    always @(posedge clk) begin
        timer_event_t want;
        if (rst_n) begin
            if (in_valid && in_ready)
                predict_timers();
            if (out_valid && out_ready) begin
                if (due_events.size() == 0) begin
                    report("unexpected result kind", kind, 0);
                end else begin
                    want = due_events.pop_front();
                    if (kind !== want.kind)
                        report("kind", kind, want.kind);
                    if (timer_id !== want.id)
                        report("timer_id", timer_id, want.id);
                    if (fired_tag !== want.tag)
                        report("fired_tag", fired_tag, want.tag);
                    if (last !== want.last)
                        report("last", last, want.last);
                end
            end
        end
    end

endmodule

// ----- dv/tb_sorted_event_timer_table_core.sv -----
`timescale 1ns / 100ps

module tb_sorted_event_timer_table_core;
    import sett_pkg::*;

    localparam int  RANDOM_ITEMS = 330;
    localparam int  CYCLE_LIMIT  = 20000000;
    localparam int  DRAIN_CYCLES = 4000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     opcode;
    logic [TIME_W-1:0]   now_ms;
    logic [DLY_W-1:0]    delay_ms;
    logic                periodic;
    logic [TAG_W-1:0]    event_tag;
    logic [ID_W-1:0]     cancel_id;
    logic                out_valid;
    logic                out_ready;
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     timer_id;
    logic [TAG_W-1:0]    fired_tag;
    logic                last;

    int                  fail_count;
    int                  pending;
    int                  fire_count;
    int                  cycle_count;
    int                  sent_count;
    bit                  no_idle;     // stretch where neither side idles
    logic [TIME_W-1:0]   clock_ms;    // running time base for random traffic

    sorted_event_timer_table_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .now_ms    (now_ms),
        .delay_ms  (delay_ms),
        .periodic  (periodic),
        .event_tag (event_tag),
        .cancel_id (cancel_id),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .timer_id  (timer_id),
        .fired_tag (fired_tag),
        .last      (last)
    );

    sett_result_checker CHK (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .now_ms     (now_ms),
        .delay_ms   (delay_ms),
        .periodic   (periodic),
        .event_tag  (event_tag),
        .cancel_id  (cancel_id),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .timer_id   (timer_id),
        .fired_tag  (fired_tag),
        .last       (last),
        .fail_count (fail_count),
        .pending    (pending),
        .fire_count (fire_count)
    );

    // Free-running clock, 10 ns period
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Guard against a hung handshake: end the run as failed
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Draw a random per-item wait, none during a no-idle stretch
    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    // Send one item: idle for a random gap, raise valid, hold until transfer
    task automatic send_item(logic [OP_W-1:0] op, logic [TIME_W-1:0] t,
                             logic [DLY_W-1:0] d, logic per,
                             logic [TAG_W-1:0] tag, logic [ID_W-1:0] cid);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        opcode    = op;
        now_ms    = t;
        delay_ms  = d;
        periodic  = per;
        event_tag = tag;
        cancel_id = cid;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        if (op != OP_UNUSED)
            sent_count++;
    endtask

    // Random 48-bit value covering every bit
    function automatic logic [TIME_W-1:0] any_time();
        return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
    endfunction

    // Result side: wait a random gap per result, then hold ready until transfer
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int pick;
        in_valid   = 1'b0;
        opcode     = OP_CREATE;
        now_ms     = '0;
        delay_ms   = '0;
        periodic   = 1'b0;
        event_tag  = '0;
        cancel_id  = '0;
        no_idle    = 1'b0;
        sent_count = 0;
        clock_ms   = '0;
        rst_n      = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty table, bogus cancels, saturation, zero period, ties
        send_item(OP_EVAL,   '0, '0, 1'b0, '0, '0);
        send_item(OP_CANCEL, '0, '0, 1'b0, '0, 8'd0);
        send_item(OP_CANCEL, '0, '0, 1'b0, '0, 8'd255);
        send_item(OP_CANCEL, '0, '0, 1'b0, '0, 8'd33);
        send_item(OP_CANCEL, '0, '0, 1'b0, '0, 8'd5);
        send_item(OP_CREATE, {TIME_W{1'b1}}, {DLY_W{1'b1}}, 1'b1, {TAG_W{1'b1}}, '0);
        send_item(OP_CREATE, '0, '0, 1'b1, 32'h0000_00A5, '0);
        send_item(OP_CREATE, 48'd10, 32'd5, 1'b0, 32'h5A5A_0001, '0);
        send_item(OP_CREATE, 48'd12, 32'd3, 1'b0, 32'h5A5A_0002, '0);
        send_item(OP_EVAL,   48'd15, '0, 1'b0, '0, '0);
        send_item(OP_UNUSED, any_time(), $urandom(), 1'b1, $urandom(), 8'hFF);
        send_item(OP_EVAL,   48'd15, '0, 1'b0, '0, '0);
        send_item(OP_CANCEL, '0, '0, 1'b0, '0, 8'd1);
        send_item(OP_CANCEL, '0, '0, 1'b0, '0, 8'd2);
        send_item(OP_EVAL,   {TIME_W{1'b1}}, '0, 1'b0, '0, '0);

        // Fill the table past capacity, then fire every entry in one pass
        for (int i = 0; i < MAX_TIMERS_DFLT + 2; i++)
            send_item(OP_CREATE, 48'd100, i % 4, i[0], $urandom(), '0);
        send_item(OP_EVAL, 48'd200, '0, 1'b0, '0, '0);
        send_item(OP_EVAL, {TIME_W{1'b1}}, '0, 1'b0, '0, '0);
        for (int i = 1; i <= MAX_TIMERS_DFLT; i++)
            send_item(OP_CANCEL, '0, '0, 1'b0, '0, i[ID_W-1:0]);

        // Random traffic around a slowly advancing time base
        clock_ms = 48'd1000;
        while (sent_count < RANDOM_ITEMS)
        begin
            if (sent_count % 40 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 42)
                send_item(OP_CREATE, clock_ms,
                          ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 300),
                          1'($urandom_range(0, 1)), $urandom(), 8'($urandom()));
            else if (pick < 47)
                send_item(OP_CREATE, any_time(), $urandom(), 1'($urandom_range(0, 1)),
                          $urandom(), 8'($urandom()));
            else if (pick < 67)
                send_item(OP_CANCEL, any_time(), $urandom(), 1'($urandom_range(0, 1)),
                          $urandom(),
                          8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 33)));
            else if (pick < 95)
            begin
                clock_ms = clock_ms + $urandom_range(0, 200);
                send_item(OP_EVAL, clock_ms, $urandom(), 1'($urandom_range(0, 1)),
                          $urandom(), 8'($urandom()));
            end
            else if (pick < 97)
                send_item(OP_EVAL, any_time(), $urandom(), 1'b0, $urandom(),
                          8'($urandom()));
            else
                send_item(OP_UNUSED, any_time(), $urandom(), 1'($urandom_range(0, 1)),
                          $urandom(), 8'($urandom()));
        end
        in_valid = 1'b0;

        // Drain outstanding results, then let the block settle
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items (create, cancel, evaluate), %0d timer expiries checked,",
                 sent_count, fire_count);
        $display("including a full table, saturated expiry and zero-period timers.");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/sett_pkg.sv
src/sett_ram.sv
src/sorted_event_timer_table_core.sv
dv/sett_result_checker.sv
dv/tb_sorted_event_timer_table_core.sv
